// File: hw/rtl/fldx_pkg.sv
// Package for the binary64 frexp/ldexp unit: operation codes, field widths,
// IEEE binary64 constants and the request/decomposition structs.
// No dependencies.
package fldx_pkg;

  localparam int unsigned WordW   = 64;
  localparam int unsigned FracW   = 52;
  localparam int unsigned BexpW   = 11;
  localparam int unsigned ScaleW  = 13;
  localparam int unsigned ExpOutW = 12;
  localparam int unsigned TargetW = 14;
  localparam int unsigned MantW   = FracW + 1;
  localparam int unsigned ShiftW  = 6;

  localparam logic [BexpW-1:0] BexpAllOnes = 11'h7ff;  // 2047: infinity / NaN
  localparam logic [BexpW-1:0] BexpHalf    = 11'h3fe;  // exponent of 0.5
  localparam logic [ExpOutW-1:0] FrexpBias = 12'd1022;

  typedef enum logic [0:0] {
    FUNC_FREXP = 1'b0,
    FUNC_LDEXP = 1'b1
  } func_e;

  // Registered request at the input stage.
  typedef struct packed {
    func_e                    func;
    logic [WordW-1:0]         value_bits;
    logic signed [ScaleW-1:0] scale_exponent;
  } req_t;

  // Decomposed operand handed from the decompose stage to the scale stage.
  typedef struct packed {
    func_e                     func;
    logic                      special;   // zero, infinity or NaN
    logic [WordW-1:0]          value_bits;
    logic [FracW-1:0]          frac;
    logic signed [ExpOutW-1:0] exp;
    logic signed [ScaleW-1:0]  scale_exponent;
  } dec_t;

endpackage

// File: hw/rtl/fldx_req_if.sv
// Request channel of the binary64 frexp/ldexp unit: valid/ready plus the
// operation, operand and scale payload. No dependencies.
interface fldx_req_if;
  logic              valid;
  logic              ready;
  logic              func;
  logic [63:0]       value_bits;
  logic signed [12:0] scale_exponent;

  modport source (output valid, func, value_bits, scale_exponent, input ready);
  modport sink   (input valid, func, value_bits, scale_exponent, output ready);
endinterface

// File: hw/rtl/fldx_rsp_if.sv
// Response channel of the binary64 frexp/ldexp unit: valid/ready plus the
// result bit pattern and frexp exponent. No dependencies.
interface fldx_rsp_if;
  logic               valid;
  logic               ready;
  logic [63:0]        result_bits;
  logic signed [11:0] exponent_out;

  modport source (output valid, result_bits, exponent_out, input ready);
  modport sink   (input valid, result_bits, exponent_out, output ready);
endinterface

// File: hw/rtl/fldx_decomp.sv
// Decompose stage: classify the operand and split it into fraction and
// frexp exponent, normalising subnormals. Depends on fldx_pkg.
module fldx_decomp (
  input  fldx_pkg::req_t req_i,
  output fldx_pkg::dec_t dec_o
);
  import fldx_pkg::*;

  logic [BexpW-1:0]   bexp;
  logic [FracW-1:0]   fr;
  logic [WordW-1:0]   norm;
  logic [ShiftW-1:0]  lz;
  logic [ExpOutW-1:0] exp_u;

  assign bexp = req_i.value_bits[62:52];
  assign fr   = req_i.value_bits[FracW-1:0];

  // Leading-zero normalisation of the subnormal fraction in six halving steps.
  always_comb begin
    norm = {fr, 12'b0};
    lz   = '0;
    if (norm[63:32] == '0) begin norm = norm << 32; lz[5] = 1'b1; end
    if (norm[63:48] == '0) begin norm = norm << 16; lz[4] = 1'b1; end
    if (norm[63:56] == '0) begin norm = norm << 8;  lz[3] = 1'b1; end
    if (norm[63:60] == '0) begin norm = norm << 4;  lz[2] = 1'b1; end
    if (norm[63:62] == '0) begin norm = norm << 2;  lz[1] = 1'b1; end
    if (norm[63] == 1'b0) begin norm = norm << 1;  lz[0] = 1'b1; end
  end

  always_comb begin
    dec_o.func           = req_i.func;
    dec_o.value_bits     = req_i.value_bits;
    dec_o.scale_exponent = req_i.scale_exponent;
    dec_o.special        = (req_i.value_bits[62:0] == '0) || (bexp == BexpAllOnes);
    if (bexp != '0) begin
      dec_o.frac = fr;
      exp_u      = {1'b0, bexp} - FrexpBias;
    end else begin
      // drop the leading one; exponent is -1022 minus the leading zeros
      dec_o.frac = norm[62:11];
      exp_u      = 12'd0 - FrexpBias - {{(ExpOutW-ShiftW){1'b0}}, lz};
    end
    dec_o.exp = $signed(exp_u);
  end

endmodule

// File: hw/rtl/fldx_scale.sv
// Scale stage: build the frexp fraction or the ldexp result with overflow,
// underflow and round-half-to-even of subnormals. Depends on fldx_pkg.
module fldx_scale (
  input  fldx_pkg::dec_t             dec_i,
  output logic [fldx_pkg::WordW-1:0] result_bits_o,
  output logic signed [fldx_pkg::ExpOutW-1:0] exponent_out_o
);
  import fldx_pkg::*;

  logic                       sign;
  logic signed [TargetW-1:0]  target;
  logic [TargetW-1:0]         shift_full;
  logic [ShiftW-1:0]          shift;
  logic [MantW-1:0]           mant;
  logic [2*MantW-1:0]         wide;
  logic [MantW-1:0]           kept;
  logic                       guard;
  logic                       sticky;
  logic                       round_up;
  logic [MantW-1:0]           kept_r;
  logic [WordW-1:0]           ldexp_bits;

  assign sign   = dec_i.value_bits[63];
  assign mant   = {1'b1, dec_i.frac};
  assign target = $signed({{(TargetW-ExpOutW){dec_i.exp[ExpOutW-1]}}, dec_i.exp})
                + $signed({{(TargetW-ScaleW){dec_i.scale_exponent[ScaleW-1]}},
                           dec_i.scale_exponent})
                + $signed({{(TargetW-ExpOutW){1'b0}}, FrexpBias});

  // Subnormal path: right shift by 1 - target (1..53), guard and sticky below.
  assign shift_full = 14'd1 - target;
  assign shift      = shift_full[ShiftW-1:0];
  assign wide       = {mant, {MantW{1'b0}}} >> shift;
  assign kept       = wide[2*MantW-1:MantW];
  assign guard      = wide[MantW-1];
  assign sticky     = |wide[MantW-2:0];
  assign round_up   = guard && (sticky || kept[0]);
  assign kept_r     = kept + {{(MantW-1){1'b0}}, round_up};  // carry may reach normal

  always_comb begin
    priority if (target >= 14'sd2047) begin
      ldexp_bits = {sign, BexpAllOnes, {FracW{1'b0}}};
    end else if (target > 14'sd0) begin
      ldexp_bits = {sign, target[BexpW-1:0], dec_i.frac};
    end else if (target < -14'sd52) begin
      ldexp_bits = {sign, {(WordW-1){1'b0}}};
    end else begin
      ldexp_bits = {sign, {(WordW-1-MantW){1'b0}}, kept_r};
    end
  end

  always_comb begin
    result_bits_o  = dec_i.value_bits;
    exponent_out_o = '0;
    if (!dec_i.special) begin
      unique case (dec_i.func)
        FUNC_FREXP: begin
          result_bits_o  = {sign, BexpHalf, dec_i.frac};
          exponent_out_o = dec_i.exp;
        end
        FUNC_LDEXP: begin
          result_bits_o  = ldexp_bits;
        end
        default: begin
          result_bits_o  = dec_i.value_bits;
        end
      endcase
    end
  end

endmodule

// File: hw/rtl/binary64_frexp_ldexp_unit.sv
// binary64_frexp_ldexp_unit: top level, a two-register frexp/ldexp datapath.
// Depends on fldx_pkg, fldx_req_if, fldx_rsp_if, fldx_decomp and fldx_scale.
//
// Usage: each request carries func (0 frexp, 1 ldexp), a binary64 operand and
// a signed 13-bit scale. Frexp returns the fraction in [0.5,1) with the
// operand's sign and the exponent; ldexp returns the operand times two to the
// scale, giving signed infinity on overflow, signed zero far below the
// subnormal range and round-half-to-even on subnormal results. Zero, infinity
// and NaN come back unchanged with exponent 0; ldexp always reports exponent 0.
// One request is taken every clock cycle while ready is high, and its response
// passes through an input register, then one pass of combinational logic
// (leading-zero normalisation, scaling and rounding) into a result register.
// Each register holds one request, so up to two are in flight; when the
// response is stalled the result register holds, the input register fills
// behind it and ready drops only once both are occupied. Reset clears the
// stage valid flags only.
module binary64_frexp_ldexp_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  fldx_req_if.sink   req_i,
  fldx_rsp_if.source rsp_o
);
  import fldx_pkg::*;

  // Stage valid flags.
  logic s1_v_q, s1_v_d;
  logic s2_v_q, s2_v_d;

  // Stage advance enables: a stage moves on when empty or its successor moves.
  logic adv1, adv2;

  // Stage payloads.
  req_t                      s1_req_q;
  dec_t                      dec;
  logic [WordW-1:0]          s2_res_q;
  logic signed [ExpOutW-1:0] s2_exp_q;
  func_e                     s2_func_q;
  logic [WordW-1:0]          res;
  logic signed [ExpOutW-1:0] res_exp;

  assign adv2 = !s2_v_q || rsp_o.ready;
  assign adv1 = !s1_v_q || adv2;

  assign req_i.ready = adv1;

  // Advance valid flags; hold when the next stage is blocked.
  assign s1_v_d = adv1 ? req_i.valid : s1_v_q;
  assign s2_v_d = adv2 ? s1_v_q      : s2_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      s1_v_q <= s1_v_d;
      s2_v_q <= s2_v_d;
    end
  end

  // Decompose: classify and normalise the registered operand.
  fldx_decomp u_decomp (
    .req_i (s1_req_q),
    .dec_o (dec)
  );

  // Scale: form the frexp or ldexp result.
  fldx_scale u_scale (
    .dec_i          (dec),
    .result_bits_o  (res),
    .exponent_out_o (res_exp)
  );

  // Payload registers need no reset; load whenever the stage advances.
  always_ff @(posedge clk_i) begin
    if (adv1) begin
      s1_req_q.func           <= func_e'(req_i.func);
      s1_req_q.value_bits     <= req_i.value_bits;
      s1_req_q.scale_exponent <= req_i.scale_exponent;
    end
    if (adv2) begin
      s2_res_q  <= res;
      s2_exp_q  <= res_exp;
      s2_func_q <= dec.func;
    end
  end

  assign rsp_o.valid        = s2_v_q;
  assign rsp_o.result_bits  = s2_res_q;
  assign rsp_o.exponent_out = s2_exp_q;

  // A full datapath behind a stalled response must refuse new requests.
  a_full_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_v_q && s2_v_q && !rsp_o.ready) |-> !req_i.ready)
    else $error("request taken while all stages are full and stalled");

  // An accepted request must occupy the input stage on the next cycle.
  a_accept_fill : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> s1_v_q)
    else $error("accepted request lost at the input stage");

  // Ldexp results never report an exponent.
  a_ldexp_exp0 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_v_q && s2_func_q == FUNC_LDEXP) |-> (s2_exp_q == '0))
    else $error("ldexp response with nonzero exponent");

  // A frexp response with a nonzero exponent is a fraction in [0.5,1).
  a_frexp_half : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_v_q && s2_func_q == FUNC_FREXP && s2_exp_q != '0)
      |-> (s2_res_q[62:52] == BexpHalf))
    else $error("frexp fraction outside [0.5,1)");

endmodule
